### hdl/lfbc_pkg.sv
`default_nettype none
package lfbc_pkg;

  // Default number of regions covered by the size and magic tables.
  localparam int REGION_COUNT_DEF = 4096;

  // Depth of the command queue between the front and the back (power of two).
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes and reset values.
  localparam int CFG_DATA_W = 12;
  localparam logic CFG_REGION_SHIFT = 1'b0;
  localparam logic CFG_REDZONE      = 1'b1;
  localparam logic [5:0]  REGION_SHIFT_RST = 6'd35;
  localparam logic [11:0] REDZONE_RST      = 12'd16;

  // Input modes.
  localparam logic [1:0] MODE_TABLE = 2'd0;
  localparam logic [1:0] MODE_CHECK = 2'd1;
  localparam logic [1:0] MODE_META  = 2'd2;

  // Verdict codes.
  localparam logic [2:0] VERDICT_FETCH     = 3'd0;
  localparam logic [2:0] VERDICT_OK        = 3'd1;
  localparam logic [2:0] VERDICT_UNTRACKED = 3'd2;
  localparam logic [2:0] VERDICT_OOB       = 3'd3;
  localparam logic [2:0] VERDICT_UAF       = 3'd4;
  localparam logic [2:0] VERDICT_CORRUPT   = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] region_index;
    logic [35:0] region_object_size;
    logic [63:0] region_magic;
    logic [63:0] base_pointer;
    logic [63:0] access_address;
    logic [6:0]  access_bytes;
    logic [63:0] base_object_meta;
    logic [63:0] access_object_meta;
  } req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [63:0] base_meta_address;
    logic [63:0] access_meta_address;
    logic [63:0] access_object_low;
    logic [63:0] access_object_high;
  } rsp_t;

  // One region table entry.
  typedef struct packed {
    logic [35:0] size;
    logic [63:0] magic;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_CHECK,
    CMD_UNTRACKED,
    CMD_META
  } cmd_kind_t;

  // Work handed from the front to the back. For a check, a is the base
  // pointer and b the access address; for metadata, a is the base size
  // word and b the access size word.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [63:0] a;
    logic [63:0] b;
    logic [6:0]  bytes;
    logic [35:0] size;
    logic [63:0] magic;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_META1,
    B_META2,
    B_EMIT
  } back_state_t;

endpackage
`default_nettype wire

### hdl/lfbc_front.sv
`default_nettype none
module lfbc_front #(
  parameter int REGION_COUNT = lfbc_pkg::REGION_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire lfbc_pkg::req_t  req,
  input  wire logic [5:0]      region_shift,
  input  wire logic            q_full,
  output logic                 q_push,
  output lfbc_pkg::cmd_t       q_cmd
);

  localparam int IDX_W = $clog2(REGION_COUNT);

  lfbc_pkg::entry_t mem [REGION_COUNT];
  lfbc_pkg::entry_t rd_q;

  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  logic                f1_valid;
  lfbc_pkg::cmd_kind_t f1_kind;
  logic [63:0]         f1_a;
  logic [63:0]         f1_b;
  logic [6:0]          f1_bytes;

  logic             accept;
  logic [63:0]      shifted;
  logic             idx_in_range;
  logic [63:0]      widx64;
  logic             widx_ok;
  logic             tbl_write;
  logic             rd_en;

  assign req_stall = clearing || (f1_valid && q_full);
  assign accept    = req_valid && !req_stall;

  assign shifted      = req.access_address >> region_shift;
  assign idx_in_range = shifted < 64'(REGION_COUNT);
  assign widx64       = {52'b0, req.region_index};
  assign widx_ok      = widx64 < 64'(REGION_COUNT);
  assign tbl_write    = accept && (req.mode == lfbc_pkg::MODE_TABLE) && widx_ok;
  assign rd_en        = accept && (req.mode == lfbc_pkg::MODE_CHECK);

  // Clear sweep after reset, one entry a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == IDX_W'(REGION_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (tbl_write) begin
      mem[widx64[IDX_W-1:0]] <= '{size: req.region_object_size, magic: req.region_magic};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[shifted[IDX_W-1:0]];
    end
  end

  assign q_push = f1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept &&
                 (req.mode inside {lfbc_pkg::MODE_CHECK, lfbc_pkg::MODE_META})) begin
      f1_valid <= 1'b1;
    end else if (q_push) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.mode == lfbc_pkg::MODE_CHECK) begin
      f1_kind  <= idx_in_range ? lfbc_pkg::CMD_CHECK : lfbc_pkg::CMD_UNTRACKED;
      f1_a     <= req.base_pointer;
      f1_b     <= req.access_address;
      f1_bytes <= req.access_bytes;
    end else if (accept && req.mode == lfbc_pkg::MODE_META) begin
      f1_kind  <= lfbc_pkg::CMD_META;
      f1_a     <= req.base_object_meta;
      f1_b     <= req.access_object_meta;
      f1_bytes <= '0;
    end
  end

  always_comb begin
    q_cmd.kind  = f1_kind;
    q_cmd.a     = f1_a;
    q_cmd.b     = f1_b;
    q_cmd.bytes = f1_bytes;
    q_cmd.size  = rd_q.size;
    q_cmd.magic = rd_q.magic;
  end

endmodule
`default_nettype wire

### hdl/lfbc_queue.sv
`default_nettype none
module lfbc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lfbc_pkg::cmd_t cmd_in,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output lfbc_pkg::cmd_t      head
);

  localparam int PTR_W = $clog2(lfbc_pkg::QUEUE_DEPTH);

  lfbc_pkg::cmd_t slots [lfbc_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W:0]   count;

  assign full       = count == (PTR_W + 1)'(lfbc_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/lfbc_back.sv
`default_nettype none
module lfbc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire lfbc_pkg::cmd_t  q_head,
  output logic                 q_pop,
  input  wire logic [11:0]     redzone_bytes,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output lfbc_pkg::rsp_t       rsp
);

  // Steps of the shared 32x32 multiplier per operand.
  localparam logic [3:0] STEP_LL   = 4'd0;
  localparam logic [3:0] STEP_LH   = 4'd1;
  localparam logic [3:0] STEP_HL   = 4'd2;
  localparam logic [3:0] STEP_HH   = 4'd3;
  localparam logic [3:0] STEP_Q    = 4'd4;
  localparam logic [3:0] STEP_QLSL = 4'd5;
  localparam logic [3:0] STEP_QHSL = 4'd6;
  localparam logic [3:0] STEP_QLSH = 4'd7;
  localparam logic [3:0] STEP_DONE = 4'd8;

  lfbc_pkg::back_state_t state, state_next;

  lfbc_pkg::cmd_t w;
  logic [3:0]     st;
  logic           opnd;
  logic           out_free;
  logic           rsp_load;

  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  mul_p;
  logic [63:0]  p;
  logic [127:0] prod;
  logic [63:0]  res;
  logic [63:0]  res_final;
  logic [63:0]  x;
  logic [63:0]  bmeta_r;
  logic [63:0]  ameta_r;

  logic        pending;
  logic [63:0] held_acc;
  logic [6:0]  held_bytes;
  logic [35:0] held_size;
  logic [63:0] held_bmeta;
  logic [63:0] held_ameta;

  logic [65:0] lb;
  logic [65:0] lb_r;
  logic        lb_ok_r;
  logic [64:0] aend_r;
  logic [63:0] alb_r;
  logic        bsize_lt_r;
  logic [65:0] ub;
  logic        pass_r;
  logic [63:0] aub_r;
  logic [2:0]  verdict_r;

  lfbc_pkg::rsp_t rsp_next;

  assign out_free = !rsp_valid || !rsp_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lfbc_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_head.kind)
            lfbc_pkg::CMD_CHECK:     state_next = lfbc_pkg::B_MUL;
            lfbc_pkg::CMD_UNTRACKED: state_next = lfbc_pkg::B_EMIT;
            lfbc_pkg::CMD_META:      state_next = pending ? lfbc_pkg::B_META1 : lfbc_pkg::B_IDLE;
            default:                 state_next = lfbc_pkg::B_IDLE;
          endcase
        end
      end
      lfbc_pkg::B_MUL: begin
        if (st == STEP_DONE && opnd) begin
          state_next = lfbc_pkg::B_EMIT;
        end
      end
      lfbc_pkg::B_META1: state_next = lfbc_pkg::B_META2;
      lfbc_pkg::B_META2: state_next = lfbc_pkg::B_EMIT;
      lfbc_pkg::B_EMIT: begin
        if (out_free) begin
          state_next = lfbc_pkg::B_IDLE;
        end
      end
      default: state_next = lfbc_pkg::B_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop    = (state == lfbc_pkg::B_IDLE) && q_valid;
    rsp_load = (state == lfbc_pkg::B_EMIT) && out_free;
  end

  // Operand select: base pointer first, then access address.
  assign x = opnd ? w.b : w.a;

  always_comb begin
    case (st)
      STEP_LL:   begin mul_a = w.magic[31:0];  mul_b = x[31:0];  end
      STEP_LH:   begin mul_a = w.magic[31:0];  mul_b = x[63:32]; end
      STEP_HL:   begin mul_a = w.magic[63:32]; mul_b = x[31:0];  end
      STEP_HH:   begin mul_a = w.magic[63:32]; mul_b = x[63:32]; end
      STEP_QLSL: begin mul_a = prod[95:64];    mul_b = w.size[31:0]; end
      STEP_QHSL: begin mul_a = prod[127:96];   mul_b = w.size[31:0]; end
      STEP_QLSH: begin mul_a = prod[95:64];    mul_b = {28'b0, w.size[35:32]}; end
      default:   begin mul_a = '0;             mul_b = '0; end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign res_final = res + {p[31:0], 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfbc_pkg::B_IDLE;
      st        <= '0;
      opnd      <= 1'b0;
      pending   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        st   <= '0;
        opnd <= 1'b0;
      end else if (state == lfbc_pkg::B_MUL) begin
        if (st == STEP_DONE) begin
          st   <= '0;
          opnd <= 1'b1;
        end else begin
          st <= st + 1'b1;
        end
      end
      if (rsp_load) begin
        pending <= (w.kind == lfbc_pkg::CMD_CHECK) && (bmeta_r != '0);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Multiplier datapath.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      w <= q_head;
    end
    if (state == lfbc_pkg::B_MUL) begin
      p <= mul_p;
      case (st)
        STEP_LH:   prod <= {64'b0, p};
        STEP_HL:   prod <= prod + {32'b0, p, 32'b0};
        STEP_HH:   prod <= prod + {32'b0, p, 32'b0};
        STEP_Q:    prod <= prod + {p, 64'b0};
        STEP_QHSL: res  <= p;
        STEP_QLSH: res  <= res + {p[31:0], 32'b0};
        STEP_DONE: begin
          if (opnd) begin
            ameta_r <= res_final;
          end else begin
            bmeta_r <= res_final;
          end
        end
        default: prod <= prod;
      endcase
    end
  end

  // Bounds arithmetic on the held check.
  assign lb = {2'b0, held_bmeta} + 66'(redzone_bytes);
  assign ub = lb_r + {2'b0, w.a};

  always_ff @(posedge clk) begin
    if (state == lfbc_pkg::B_META1) begin
      lb_r       <= lb;
      lb_ok_r    <= lb <= {2'b0, held_acc};
      aend_r     <= {1'b0, held_acc} + 65'(held_bytes);
      alb_r      <= held_ameta + 64'(redzone_bytes);
      bsize_lt_r <= w.a < {28'b0, held_size};
    end
    if (state == lfbc_pkg::B_META2) begin
      pass_r <= lb_ok_r && ({1'b0, aend_r} <= ub) && bsize_lt_r;
      aub_r  <= alb_r + ((w.b == '0) ? {28'b0, held_size} : w.b);
      if (w.a == '0 && w.b == '0) begin
        verdict_r <= lfbc_pkg::VERDICT_UAF;
      end else if (w.a > {28'b0, held_size}) begin
        verdict_r <= lfbc_pkg::VERDICT_CORRUPT;
      end else begin
        verdict_r <= lfbc_pkg::VERDICT_OOB;
      end
    end
  end

  // Hold the check that waits for its metadata.
  always_ff @(posedge clk) begin
    if (rsp_load && w.kind == lfbc_pkg::CMD_CHECK) begin
      held_acc   <= w.b;
      held_bytes <= w.bytes;
      held_size  <= w.size;
      held_bmeta <= bmeta_r;
      held_ameta <= ameta_r;
    end
  end

  always_comb begin
    rsp_next = '0;
    case (w.kind)
      lfbc_pkg::CMD_UNTRACKED: rsp_next.verdict = lfbc_pkg::VERDICT_UNTRACKED;
      lfbc_pkg::CMD_CHECK: begin
        if (bmeta_r == '0) begin
          rsp_next.verdict = lfbc_pkg::VERDICT_UNTRACKED;
        end else begin
          rsp_next.verdict             = lfbc_pkg::VERDICT_FETCH;
          rsp_next.base_meta_address   = bmeta_r;
          rsp_next.access_meta_address = ameta_r;
        end
      end
      lfbc_pkg::CMD_META: begin
        if (pass_r) begin
          rsp_next.verdict = lfbc_pkg::VERDICT_OK;
        end else begin
          rsp_next.verdict            = verdict_r;
          rsp_next.access_object_low  = alb_r;
          rsp_next.access_object_high = aub_r;
        end
      end
      default: rsp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

### hdl/low_fat_bounds_checker_top.sv
// Low-fat pointer bounds checker.
// Request channel (req_valid/req_stall/req): mode 0 loads one region's slot
// size and magic, mode 1 checks a memory access, mode 2 delivers the two size
// words fetched after a check. A transaction moves when valid is high and
// stall is low. Response channel (rsp_valid/rsp_stall/rsp) carries one verdict
// for each check and for each metadata transaction that answers a fetch verdict.
// Configuration (cfg_we/cfg_index/cfg_data) sets region_shift and
// redzone_bytes; write only while the block is idle.
// A table write goes straight into the table. A check inside the tables passes
// the front register and the queue, then occupies the back end while one shared
// 32x32 multiplier runs 9 steps for each of the two metadata addresses.
// A check past the end of the tables goes straight to the emit state, and a
// metadata transaction passes the META1 and META2 bounds states. The front end
// and a two-entry command queue keep taking requests while the back works.
// Reset: the region tables are swept to zero, one entry a cycle, and req_stall
// stays high during the sweep. Configuration returns to shift 35 and 16
// redzone bytes.
// A stalled response holds in the output register; the back end waits,
// then the queue fills and req_stall rises.
`default_nettype none
module low_fat_bounds_checker_top #(
  parameter int REGION_COUNT = lfbc_pkg::REGION_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire lfbc_pkg::req_t                  req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output lfbc_pkg::rsp_t                       rsp,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [lfbc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [5:0]  region_shift;
  logic [11:0] redzone_bytes;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  lfbc_pkg::cmd_t q_cmd;
  lfbc_pkg::cmd_t q_head;

  // Configuration registers: take the write on the enable edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_shift  <= lfbc_pkg::REGION_SHIFT_RST;
      redzone_bytes <= lfbc_pkg::REDZONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lfbc_pkg::CFG_REGION_SHIFT: region_shift  <= cfg_data[5:0];
        lfbc_pkg::CFG_REDZONE:      redzone_bytes <= cfg_data[11:0];
        default:                    region_shift  <= region_shift;
      endcase
    end
  end

  // Front: table writes, table lookup and classification of checks.
  lfbc_front #(
    .REGION_COUNT(REGION_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .region_shift (region_shift),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Decouple front and back so each side can stall on its own.
  lfbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .cmd_in     (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // Back: metadata address multiplies, bounds verdicts, response register.
  lfbc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .redzone_bytes (redzone_bytes),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp)
  );

endmodule
`default_nettype wire

### bench/low_fat_bounds_checker_top_tb.sv
module low_fat_bounds_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfbc_pkg::*;

  localparam int REGIONS = REGION_COUNT_DEF;
  // Mode 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1600;
  localparam int RANDOM_PHASES = 6;
  localparam int REPORT_LIMIT = 20;

  // Shapes of a well-formed check/metadata pair.
  typedef enum int {
    OUT_OK,
    OUT_OOB,
    OUT_UAF,
    OUT_CORRUPT,
    OUT_EQUAL,
    OUT_FREED
  } outcome_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PATTERN,
    STALL_HEAVY
  } stall_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_REGION_SHIFT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  low_fat_bounds_checker_top DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block: region tables, the open check and the registers.
  logic [35:0] size_tab [REGIONS] = '{default: '0};
  logic [63:0] magic_tab [REGIONS] = '{default: '0};
  logic        check_open = 1'b0;
  logic [63:0] open_access = '0;
  logic [6:0]  open_bytes = '0;
  logic [35:0] open_size = '0;
  logic [63:0] open_base_meta = '0;
  logic [63:0] open_access_meta = '0;
  logic [5:0]  shift_cfg = REGION_SHIFT_RST;
  logic [11:0] redzone_cfg = REDZONE_RST;

  // Verdicts still owed by the block, oldest first.
  rsp_t expected_verdicts[$];

  int live_regions[$];
  int tracked_items = 0;
  int items_moved = 0;
  int verdicts_checked = 0;
  int settings_applied = 0;
  int mismatches = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit holdoff_pending = 1'b0;
  stall_style_t stall_style = STALL_LIGHT;
  int hold_left = 0;
  int stall_phase = 0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Address of an allocation's size word: high half of magic * ptr, times slot.
  function automatic logic [63:0] meta_address(input logic [63:0] magic,
                                               input logic [35:0] slot,
                                               input logic [63:0] ptr);
    logic [127:0] prod;
    prod = {64'd0, magic} * {64'd0, ptr};
    return prod[127:64] * {28'd0, slot};
  endfunction

  function automatic logic [63:0] slot_magic(input logic [35:0] slot);
    if (slot == '0) return '0;
    return (64'hFFFF_FFFF_FFFF_FFFF / 64'(slot)) + 64'd1;
  endfunction

  // Work out the verdict (if any) for one accepted transaction and queue it.
  function automatic void predict(input req_t t);
    rsp_t        e;
    logic [63:0] idx;
    logic [63:0] asize;
    logic [65:0] lb, ub, aend, alb, aub;
    e = '0;
    case (t.mode)
      MODE_TABLE: begin
        size_tab[t.region_index] = t.region_object_size;
        magic_tab[t.region_index] = t.region_magic;
        tracked_items++;
      end
      MODE_CHECK: begin
        tracked_items++;
        idx = t.access_address >> shift_cfg;
        if (idx >= 64'(REGIONS)) begin
          check_open = 1'b0;
          e.verdict = VERDICT_UNTRACKED;
        end else begin
          e.base_meta_address = meta_address(magic_tab[idx[11:0]], size_tab[idx[11:0]],
                                             t.base_pointer);
          if (e.base_meta_address == '0) begin
            check_open = 1'b0;
            e.verdict = VERDICT_UNTRACKED;
          end else begin
            e.verdict = VERDICT_FETCH;
            e.access_meta_address = meta_address(magic_tab[idx[11:0]], size_tab[idx[11:0]],
                                                 t.access_address);
            check_open = 1'b1;
            open_access = t.access_address;
            open_bytes = t.access_bytes;
            open_size = size_tab[idx[11:0]];
            open_base_meta = e.base_meta_address;
            open_access_meta = e.access_meta_address;
          end
        end
        expected_verdicts.push_back(e);
      end
      MODE_META: begin
        if (check_open) begin
          tracked_items++;
          check_open = 1'b0;
          // Bound sums are exact: keep two spare bits above the word.
          lb = 66'(open_base_meta) + 66'(redzone_cfg);
          ub = lb + 66'(t.base_object_meta);
          aend = 66'(open_access) + 66'(open_bytes);
          if (lb <= 66'(open_access) && aend <= ub &&
              t.base_object_meta < 64'(open_size)) begin
            e.verdict = VERDICT_OK;
          end else begin
            asize = (t.access_object_meta == '0) ? 64'(open_size) : t.access_object_meta;
            alb = 66'(open_access_meta) + 66'(redzone_cfg);
            aub = alb + 66'(asize);
            if (t.access_object_meta == '0 && t.base_object_meta == '0)
              e.verdict = VERDICT_UAF;
            else if (t.base_object_meta > 64'(open_size))
              e.verdict = VERDICT_CORRUPT;
            else
              e.verdict = VERDICT_OOB;
            e.access_object_low = alb[63:0];
            e.access_object_high = aub[63:0];
          end
          expected_verdicts.push_back(e);
        end
      end
      default: ;
    endcase
  endfunction

  // Every field gets random in-range content; callers override what the mode uses.
  function automatic req_t blank_item(input logic [1:0] m);
    req_t t;
    t.mode = m;
    t.region_index = 12'($urandom);
    t.region_object_size = 36'(rand64() % 64'h8_0000_0001);
    t.region_magic = rand64();
    t.base_pointer = rand64();
    t.access_address = rand64();
    t.access_bytes = 7'($urandom_range(0, 64));
    t.base_object_meta = rand64();
    t.access_object_meta = rand64();
    return t;
  endfunction

  function automatic req_t table_item(input logic [11:0] idx, input logic [35:0] slot,
                                      input logic [63:0] magic);
    req_t t;
    t = blank_item(MODE_TABLE);
    t.region_index = idx;
    t.region_object_size = slot;
    t.region_magic = magic;
    return t;
  endfunction

  function automatic req_t check_item(input logic [63:0] ptr, input logic [63:0] acc,
                                      input logic [6:0] nbytes);
    req_t t;
    t = blank_item(MODE_CHECK);
    t.base_pointer = ptr;
    t.access_address = acc;
    t.access_bytes = nbytes;
    return t;
  endfunction

  function automatic req_t meta_item(input logic [63:0] bsize, input logic [63:0] asize);
    req_t t;
    t = blank_item(MODE_META);
    t.base_object_meta = bsize;
    t.access_object_meta = asize;
    return t;
  endfunction

  // Offer one transaction, hold it until accepted, then predict. Bursts of
  // back-to-back transactions are separated by random idle gaps when gaps_on is set.
  task automatic send_item(input req_t t);
    if (burst_left == 0) begin
      if (gaps_on) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req <= t;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict(t);
    items_moved++;
    burst_left--;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t mismatch in %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Drop valid and let every owed verdict arrive, then allow for work that
  // yields nothing (table writes, stray metadata) to retire.
  task automatic wait_idle();
    req_valid <= 1'b0;
    burst_left = 0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] shift, input logic [11:0] redzone);
    cfg_we <= 1'b1;
    cfg_index <= CFG_REGION_SHIFT;
    // Upper data bits are don't-care for the shift register; fill them anyway.
    cfg_data <= {6'($urandom), shift};
    @(posedge clk);
    cfg_index <= CFG_REDZONE;
    cfg_data <= redzone;
    @(posedge clk);
    cfg_we <= 1'b0;
    shift_cfg = shift;
    redzone_cfg = redzone;
    settings_applied++;
    @(posedge clk);
  endtask

  task automatic load_region(input logic [11:0] idx, input logic [35:0] slot);
    send_item(table_item(idx, slot, slot_magic(slot)));
    live_regions.push_back(int'(idx));
  endtask

  // One check on a loaded region, shaped so the following metadata lands on
  // the requested outcome. With extras on, mix in a displaced check, a table
  // write while the check is open, or a missing metadata transaction.
  task automatic run_sequence(input outcome_t kind, input logic [6:0] nbytes, input bit extras);
    int          r;
    int          pick;
    logic [35:0] slot;
    logic [63:0] span, ptr, obj, acc, bsize, asize, room, rz;
    r = live_regions[$urandom_range(0, live_regions.size() - 1)];
    slot = size_tab[r];
    rz = 64'(redzone_cfg);
    span = 64'd1 << shift_cfg;
    ptr = (64'(r) << shift_cfg) + (rand64() & (span - 64'd1));
    obj = meta_address(magic_tab[r], slot, ptr);
    bsize = (slot > 36'd1) ? 64'd1 + rand64() % (64'(slot) - 64'd1) : 64'd0;
    room = (bsize > 64'(nbytes)) ? bsize - 64'(nbytes) : 64'd0;
    acc = obj + rz + rand64() % (room + 64'd1);
    asize = bsize;
    case (kind)
      OUT_OOB: begin
        if ($urandom_range(0, 1))
          acc = obj + rz - 64'd1 - rand64() % 64'd64;
        else
          acc = obj + rz + room + 64'd1 + rand64() % 64'd64;
      end
      OUT_UAF: begin
        bsize = '0;
        asize = '0;
      end
      OUT_CORRUPT: bsize = 64'(slot) + 64'd1 + rand64() % 64'h1_0000;
      OUT_EQUAL:   bsize = 64'(slot);
      OUT_FREED: begin
        asize = '0;
        acc = obj + rz + room + 64'd1 + rand64() % 64'd64;
      end
      default: ;
    endcase
    pick = extras ? $urandom_range(0, 19) : 19;
    if (pick == 2)
      send_item(check_item(rand64(), rand64(), 7'($urandom_range(0, 64))));
    send_item(check_item(ptr, acc, nbytes));
    if (pick != 0) begin
      if (pick == 1) send_item(blank_item(MODE_TABLE));
      send_item(meta_item(bsize, asize));
    end
  endtask

  // Random transaction of any mode; half of the checks land inside the tables.
  task automatic send_noise();
    req_t t;
    t = blank_item(2'($urandom_range(0, 3)));
    if (t.mode == MODE_CHECK && $urandom_range(0, 1))
      t.access_address = t.access_address & ((64'd1 << (shift_cfg + 6'd12)) - 64'd1);
    send_item(t);
  endtask

  // Ignored mode, stray metadata, a check on an empty region, and an address
  // past the end of the table, all under reset register values.
  task automatic test_reset_state();
    send_item(blank_item(MODE_RESERVED));
    send_item(meta_item(rand64(), rand64()));
    send_item(check_item((64'd5 << shift_cfg) + 64'h40, (64'd5 << shift_cfg) + 64'h48, 7'd8));
    send_item(check_item(rand64(), 64'hFFFF_FFFF_FFFF_FFFF, 7'd64));
  endtask

  // Last and first table entries, largest slot and all-ones magic, then region 1 with slot 64.
  task automatic test_table_extremes();
    send_item(table_item(12'd4095, 36'h8_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(table_item(12'd0, 36'd0, 64'd0));
    load_region(12'd1, 36'd64);
  endtask

  task automatic test_verdicts();
    run_sequence(OUT_OK, 7'd0, 1'b0);
    run_sequence(OUT_OOB, 7'd64, 1'b0);
    run_sequence(OUT_UAF, 7'd63, 1'b0);
    run_sequence(OUT_CORRUPT, 7'd1, 1'b0);
    run_sequence(OUT_EQUAL, 7'd32, 1'b0);
  endtask

  // A new check replaces an open one, a table write leaves it open, an
  // untracked check closes it.
  task automatic test_pending_rules();
    logic [63:0] ptr1, ptr2;
    ptr1 = (64'd1 << shift_cfg) + (rand64() & ((64'd1 << shift_cfg) - 64'd1));
    // Keep the slot index nonzero after the all-ones magic of the last region.
    ptr2 = (64'd4095 << shift_cfg) + ((rand64() & 64'h7_FFFF_FFC0) | 64'h21);
    send_item(check_item(ptr1, ptr1, 7'd8));
    send_item(check_item(ptr2, ptr2 + 64'd3, 7'd64));
    // Size words of all ones push the bound sums past 64 bits.
    send_item(meta_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_item(check_item(ptr1, ptr1 + 64'd4, 7'd16));
    load_region(12'd2, 36'h7_FFFF_FFFF);
    send_item(meta_item(64'd8, 64'd8));
    send_item(check_item(ptr1, ptr1, 7'd1));
    send_item(check_item(rand64(), 64'hFFFF_FFFF_FFFF_FFFF, 7'd0));
    send_item(meta_item(64'd0, 64'd0));
  endtask

  // Register settings from both ends of the range and random ones, each with its own idling mix.
  task automatic test_random_settings();
    int          goal;
    int          n;
    logic [5:0]  shift;
    logic [11:0] redzone;
    logic [35:0] slot;
    outcome_t    kind;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       begin shift = 6'd20; redzone = 12'd0;    end
        1:       begin shift = 6'd47; redzone = 12'd4095; end
        3:       begin shift = 6'd20; redzone = 12'd4095; end
        4:       begin shift = 6'd47; redzone = 12'd0;    end
        default: begin shift = 6'($urandom_range(20, 47)); redzone = 12'($urandom); end
      endcase
      set_config(shift, redzone);
      stall_style = stall_style_t'(phase % 4);
      gaps_on = (phase % 3 != 1);
      for (n = 0; n < 6; n++) begin
        case ($urandom_range(0, 3))
          0:       slot = 36'd16 << $urandom_range(0, 14);
          1:       slot = 36'($urandom_range(1, 4096) * 16);
          2:       slot = 36'(rand64() % 64'h8_0000_0000) + 36'd1;
          default: slot = 36'h8_0000_0000;
        endcase
        load_region(12'($urandom_range(1, REGIONS - 1)), slot);
      end
      goal = tracked_items + RANDOM_ITEMS / RANDOM_PHASES;
      while (tracked_items < goal) begin
        if ($urandom_range(0, 99) < 85) begin
          kind = ($urandom_range(0, 2) == 0) ? OUT_OK : outcome_t'($urandom_range(0, 5));
          run_sequence(kind, 7'($urandom_range(0, 64)), 1'b1);
        end else begin
          send_noise();
        end
      end
    end
  endtask

  // Hold the response side off for a long stretch while requests keep coming,
  // so the command queue fills and the request side stalls.
  task automatic test_backpressure();
    wait_idle();
    stall_style = STALL_NONE;
    gaps_on = 1'b0;
    holdoff_pending = 1'b1;
    repeat (15) run_sequence(outcome_t'($urandom_range(0, 5)), 7'($urandom_range(0, 64)), 1'b0);
    gaps_on = 1'b1;
    stall_style = STALL_LIGHT;
  endtask

  // Response stall generator: a long hold-off on request, otherwise the
  // current pattern.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      stall_phase = stall_phase + 1;
      if (holdoff_pending) begin
        hold_left = HOLDOFF_CYCLES;
        holdoff_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rsp_stall <= 1'b1;
      end else begin
        case (stall_style)
          STALL_NONE:    rsp_stall <= 1'b0;
          STALL_LIGHT:   rsp_stall <= ($urandom_range(0, 3) == 0);
          STALL_PATTERN: rsp_stall <= ((stall_phase % 11) < 4);
          default:       rsp_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Compare every accepted response with the oldest owed verdict.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("response with nothing outstanding", 64'(rsp.verdict), '0);
      end else begin
        want = expected_verdicts.pop_front();
        verdicts_checked++;
        if (rsp.verdict !== want.verdict)
          report_mismatch("verdict", 64'(rsp.verdict), 64'(want.verdict));
        if (rsp.base_meta_address !== want.base_meta_address)
          report_mismatch("base_meta_address", rsp.base_meta_address, want.base_meta_address);
        if (rsp.access_meta_address !== want.access_meta_address)
          report_mismatch("access_meta_address", rsp.access_meta_address,
                          want.access_meta_address);
        if (rsp.access_object_low !== want.access_object_low)
          report_mismatch("access_object_low", rsp.access_object_low, want.access_object_low);
        if (rsp.access_object_high !== want.access_object_high)
          report_mismatch("access_object_high", rsp.access_object_high,
                          want.access_object_high);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_table_extremes();
    test_verdicts();
    test_pending_rules();
    test_random_settings();
    test_backpressure();
    wait_idle();
    $display("moved %0d request transactions, checked %0d verdicts, %0d register settings",
             items_moved, verdicts_checked, settings_applied);
    $display("included a %0d-cycle response hold-off with requests still offered",
             HOLDOFF_CYCLES);
    if (mismatches == 0) begin
      $display("low_fat_bounds_checker_top regression: pass");
    end else begin
      $display("low_fat_bounds_checker_top regression: fail");
    end
    $finish;
  end

  // Reset sweep, every check waiting out the heaviest stall pattern and the
  // hold-off, with several times margin.
  initial begin
    #5_000_000;
    $display("run timed out with %0d verdicts outstanding", expected_verdicts.size());
    $display("low_fat_bounds_checker_top regression: fail");
    $finish;
  end

endmodule
